[hw/rtl/hbac_pkg.sv]
// Shared constants and character helpers for the HTTP Basic authorization checker.
// Holds the header and scheme texts, verdict and result codes and base64 lookup.
// No dependencies.
package hbac_pkg;

    localparam int DEF_DECODE_BUFFER = 128;
    localparam int DEF_PIN_CAPACITY  = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PIN_LENGTH     = 2'd0;
    localparam logic [1:0] CFG_PIN_CHARS_LOW  = 2'd1;
    localparam logic [1:0] CFG_PIN_CHARS_HIGH = 2'd2;

    // Result codes on the output channel.
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_MISSING = 2'd1;
    localparam logic [1:0] RES_BAD     = 2'd2;

    typedef enum logic [1:0] {
        V_UNDECIDED = 2'd0,
        V_MISSING   = 2'd1,
        V_BAD       = 2'd2,
        V_DECODED   = 2'd3
    } t_verdict;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam int HDR_LEN    = 14;
    localparam int SCHEME_LEN = 6;

    // The first character sits in the most significant byte.
    localparam logic [8*HDR_LEN-1:0]    HDR_TEXT    = "authorization:";
    localparam logic [8*SCHEME_LEN-1:0] SCHEME_TEXT = "basic ";

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        for (int i = 0; i < HDR_LEN; i++) begin
            if (pos == 4'(i)) begin
                ch = HDR_TEXT[8*(HDR_LEN-1-i) +: 8];
            end
        end
        return ch;
    endfunction

    function automatic logic [7:0] scheme_char(input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        for (int i = 0; i < SCHEME_LEN; i++) begin
            if (pos == 3'(i)) begin
                ch = SCHEME_TEXT[8*(SCHEME_LEN-1-i) +: 8];
            end
        end
        return ch;
    endfunction

    // Returns {valid, sextet}.
    function automatic logic [6:0] b64_decode(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= CH_UA && c <= CH_UZ) begin
            r = {1'b1, 6'(c - CH_UA)};
        end else if (c >= CH_LA && c <= CH_LZ) begin
            r = {1'b1, 6'(c - CH_LA + 8'd26)};
        end else if (c >= CH_0 && c <= CH_9) begin
            r = {1'b1, 6'(c - CH_0 + 8'd52)};
        end else if (c == CH_PLUS) begin
            r = {1'b1, 6'd62};
        end else if (c == CH_SLASH) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    function automatic logic is_terminator(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_SP) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
    endfunction

endpackage

[hw/rtl/http_basic_auth_checker.sv]
// A verdict is registered from the item marked last as that item is accepted.
// Throughput: one request byte per cycle while o_stall is low; header match, base64 decode
// and the compares for up to three decoded password bytes sit before the result register.
// A two-entry result buffer lets bytes flow while a verdict waits downstream.
// Reset (synchronous, active low) clears all request state and the PIN registers at once.
// Depends on hbac_pkg.
module http_basic_auth_checker
    import hbac_pkg::*;
#(
    parameter int DECODE_BUFFER = DEF_DECODE_BUFFER,
    parameter int PIN_CAPACITY  = DEF_PIN_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_req_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_auth_result
);

    localparam int CNT_W     = $clog2(DECODE_BUFFER);
    localparam int IDX_W     = $clog2(PIN_CAPACITY);
    localparam int LEN_W     = $clog2(PIN_CAPACITY + 1);
    localparam int PIN_DEPTH = 2 ** IDX_W;
    localparam logic [CNT_W:0] BUF_LIM   = (CNT_W + 1)'(DECODE_BUFFER);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PIN_CAPACITY);
    localparam logic [LEN_W-1:0] PIN_TOP = LEN_W'(PIN_CAPACITY - 1);
    localparam logic [3:0] PIN_LIM4      = 4'(PIN_CAPACITY - 1);

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_WS,
        PH_SCHEME,
        PH_SPACES,
        PH_DECODE
    } t_phase;

    // Password tracking for the whole decoded text and for the part after the first colon.
    typedef struct packed {
        logic             ended;
        logic [LEN_W-1:0] whole_len;
        logic             whole_mis;
        logic             colon;
        logic [LEN_W-1:0] after_len;
        logic             after_mis;
    } t_pw;

    typedef logic [7:0] t_pin [PIN_DEPTH];

    function automatic t_pw take_byte(input t_pw s, input logic [7:0] b, input t_pin p);
        t_pw r;
        r = s;
        if (!s.ended) begin
            if (b == CH_NUL) begin
                r.ended = 1'b1;
            end else begin
                if (s.whole_len < PIN_TOP && b != p[s.whole_len[IDX_W-1:0]]) begin
                    r.whole_mis = 1'b1;
                end
                if (s.whole_len < LEN_MAX) begin
                    r.whole_len = s.whole_len + LEN_W'(1);
                end
                if (s.colon) begin
                    if (s.after_len < PIN_TOP && b != p[s.after_len[IDX_W-1:0]]) begin
                        r.after_mis = 1'b1;
                    end
                    if (s.after_len < LEN_MAX) begin
                        r.after_len = s.after_len + LEN_W'(1);
                    end
                end else if (b == CH_COLON) begin
                    r.colon = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Configuration
    logic [3:0]  r_pin_len;
    logic [63:0] r_pin_low;
    logic [55:0] r_pin_high;

    // Request state
    t_phase      r_phase, n_phase;
    logic        r_ls, n_ls;
    logic        r_cr, n_cr;
    logic [3:0]  r_hpos, n_hpos;
    logic [2:0]  r_spos, n_spos;
    logic [1:0]  r_scnt, n_scnt;
    logic [17:0] r_sbits, n_sbits;
    logic [CNT_W-1:0] r_dcnt, n_dcnt;
    t_pw         r_pw, n_pw;
    t_verdict    r_verdict, n_verdict;
    logic [1:0]  n_res;

    // Result buffer
    logic        r_out_valid;
    logic [1:0]  r_out_res;
    logic        r_skid_valid;
    logic [1:0]  r_skid_res;

    t_pin             w_pin;
    logic [LEN_W-1:0] w_pin_eff;
    logic             w_in_acc;

    assign w_in_acc      = i_valid && !r_skid_valid;
    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_auth_result = r_out_res;

    for (genvar g = 0; g < PIN_DEPTH; g++) begin : g_pin
        if (g < PIN_CAPACITY - 1 && g < 8) begin : g_low
            assign w_pin[g] = r_pin_low[8*g +: 8];
        end else if (g < PIN_CAPACITY - 1) begin : g_high
            assign w_pin[g] = r_pin_high[8*(g-8) +: 8];
        end else begin : g_none
            assign w_pin[g] = 8'h00;
        end
    end

    // The PIN ends at its first zero character within the clamped length.
    always_comb begin
        logic [3:0] lim4;
        lim4      = (r_pin_len > PIN_LIM4) ? PIN_LIM4 : r_pin_len;
        w_pin_eff = LEN_W'(lim4);
        for (int i = PIN_CAPACITY - 2; i >= 0; i--) begin
            if (4'(i) < lim4 && w_pin[i] == CH_NUL) begin
                w_pin_eff = LEN_W'(i);
            end
        end
    end

    always_comb begin
        logic [7:0]       lc;
        logic [6:0]       b64;
        logic [23:0]      quad;
        logic             go;
        logic             fin;
        logic             settle;
        logic [CNT_W:0]   dsum;
        logic [LEN_W-1:0] len;
        logic             mis;

        n_phase   = r_phase;
        n_ls      = r_ls;
        n_cr      = r_cr;
        n_hpos    = r_hpos;
        n_spos    = r_spos;
        n_scnt    = r_scnt;
        n_sbits   = r_sbits;
        n_dcnt    = r_dcnt;
        n_pw      = r_pw;
        n_verdict = r_verdict;

        lc     = to_lower(i_req_byte);
        b64    = b64_decode(i_req_byte);
        quad   = {r_sbits, b64[5:0]};
        dsum   = '0;
        fin    = 1'b0;
        go     = (r_verdict == V_UNDECIDED) && (i_req_byte != CH_NUL);
        settle = (r_verdict == V_UNDECIDED) && (i_req_byte == CH_NUL);

        if (go && r_phase == PH_SEARCH) begin
            go = 1'b0;
            if (r_ls) begin
                if (lc == hdr_char(r_hpos)) begin
                    n_hpos = r_hpos + 4'd1;
                    if (n_hpos == 4'(HDR_LEN)) begin
                        n_phase = PH_WS;
                    end
                end else begin
                    n_ls   = 1'b0;
                    n_hpos = 4'd0;
                end
            end
            if (n_phase == PH_SEARCH) begin
                if (r_cr && i_req_byte == CH_LF) begin
                    n_ls   = 1'b1;
                    n_hpos = 4'd0;
                end
                n_cr = (i_req_byte == CH_CR);
            end
        end

        if (go && n_phase == PH_WS) begin
            if (i_req_byte == CH_SP || i_req_byte == CH_TAB) begin
                go = 1'b0;
            end else begin
                n_phase = PH_SCHEME;
            end
        end

        if (go && n_phase == PH_SCHEME) begin
            go = 1'b0;
            if (lc != scheme_char(r_spos)) begin
                n_verdict = V_BAD;
            end else begin
                n_spos = r_spos + 3'd1;
                if (n_spos == 3'(SCHEME_LEN)) begin
                    n_phase = PH_SPACES;
                end
            end
        end

        if (go && n_phase == PH_SPACES) begin
            if (i_req_byte == CH_SP) begin
                go = 1'b0;
            end else begin
                n_phase = PH_DECODE;
            end
        end

        if (go && n_phase == PH_DECODE) begin
            if (is_terminator(i_req_byte)) begin
                fin = 1'b1;
            end else if (!b64[6]) begin
                n_verdict = V_BAD;
            end else if (r_scnt != 2'd3) begin
                n_sbits = {r_sbits[11:0], b64[5:0]};
                n_scnt  = r_scnt + 2'd1;
            end else begin
                n_sbits = '0;
                n_scnt  = 2'd0;
                dsum    = {1'b0, r_dcnt} + (CNT_W + 1)'(3);
                if (dsum >= BUF_LIM) begin
                    n_verdict = V_BAD;
                end else begin
                    n_pw   = take_byte(take_byte(take_byte(r_pw, quad[23:16], w_pin),
                                                 quad[15:8], w_pin), quad[7:0], w_pin);
                    n_dcnt = dsum[CNT_W-1:0];
                end
            end
        end

        if (i_last && n_verdict == V_UNDECIDED && !fin) begin
            settle = 1'b1;
        end

        // The text ended: what is pending decides the verdict.
        if (settle) begin
            if (n_phase == PH_SEARCH) begin
                n_verdict = V_MISSING;
            end else if (n_phase == PH_WS || n_phase == PH_SCHEME) begin
                n_verdict = V_BAD;
            end else begin
                fin = 1'b1;
            end
        end

        // Flush a partial group; a single leftover sextet cannot form a byte.
        if (fin) begin
            case (n_scnt)
                2'd1: begin
                    n_verdict = V_BAD;
                end
                2'd2: begin
                    dsum = {1'b0, n_dcnt} + (CNT_W + 1)'(1);
                    if (dsum >= BUF_LIM) begin
                        n_verdict = V_BAD;
                    end else begin
                        n_pw      = take_byte(n_pw, n_sbits[11:4], w_pin);
                        n_dcnt    = dsum[CNT_W-1:0];
                        n_verdict = V_DECODED;
                    end
                end
                2'd3: begin
                    dsum = {1'b0, n_dcnt} + (CNT_W + 1)'(2);
                    if (dsum >= BUF_LIM) begin
                        n_verdict = V_BAD;
                    end else begin
                        n_pw      = take_byte(take_byte(n_pw, n_sbits[17:10], w_pin),
                                              n_sbits[9:2], w_pin);
                        n_dcnt    = dsum[CNT_W-1:0];
                        n_verdict = V_DECODED;
                    end
                end
                default: begin
                    n_verdict = V_DECODED;
                end
            endcase
        end

        len = n_pw.colon ? n_pw.after_len : n_pw.whole_len;
        mis = n_pw.colon ? n_pw.after_mis : n_pw.whole_mis;
        if (w_pin_eff == '0) begin
            n_res = RES_OK;
        end else if (n_verdict == V_MISSING) begin
            n_res = RES_MISSING;
        end else if (n_verdict == V_DECODED && len == w_pin_eff && !mis) begin
            n_res = RES_OK;
        end else begin
            n_res = RES_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_len    <= 4'd0;
            r_pin_low    <= '0;
            r_pin_high   <= '0;
            r_phase      <= PH_SEARCH;
            r_ls         <= 1'b1;
            r_cr         <= 1'b0;
            r_hpos       <= 4'd0;
            r_spos       <= 3'd0;
            r_scnt       <= 2'd0;
            r_sbits      <= '0;
            r_dcnt       <= '0;
            r_pw         <= '0;
            r_verdict    <= V_UNDECIDED;
            r_out_valid  <= 1'b0;
            r_out_res    <= RES_OK;
            r_skid_valid <= 1'b0;
            r_skid_res   <= RES_OK;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_PIN_LENGTH:     r_pin_len  <= i_cfg_wdata[3:0];
                    CFG_PIN_CHARS_LOW:  r_pin_low  <= i_cfg_wdata;
                    CFG_PIN_CHARS_HIGH: r_pin_high <= i_cfg_wdata[55:0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                if (i_last) begin
                    r_phase   <= PH_SEARCH;
                    r_ls      <= 1'b1;
                    r_cr      <= 1'b0;
                    r_hpos    <= 4'd0;
                    r_spos    <= 3'd0;
                    r_scnt    <= 2'd0;
                    r_sbits   <= '0;
                    r_dcnt    <= '0;
                    r_pw      <= '0;
                    r_verdict <= V_UNDECIDED;
                end else begin
                    r_phase   <= n_phase;
                    r_ls      <= n_ls;
                    r_cr      <= n_cr;
                    r_hpos    <= n_hpos;
                    r_spos    <= n_spos;
                    r_scnt    <= n_scnt;
                    r_sbits   <= n_sbits;
                    r_dcnt    <= n_dcnt;
                    r_pw      <= n_pw;
                    r_verdict <= n_verdict;
                end
            end

            // The skid entry only fills while the output entry is held, and drains first.
            if (r_out_valid && !i_stall) begin
                if (r_skid_valid) begin
                    r_out_res    <= r_skid_res;
                    r_skid_valid <= 1'b0;
                end else if (w_in_acc && i_last) begin
                    r_out_res <= n_res;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_in_acc && i_last) begin
                if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                    r_out_res   <= n_res;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid_res   <= n_res;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds an item while the output entry is empty");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last && !r_out_valid) |=> o_valid)
        else $error("last byte accepted without a verdict appearing");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last) |=> (r_phase == PH_SEARCH && r_verdict == V_UNDECIDED && r_ls))
        else $error("request state not cleared after the last byte");

    a_dcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_dcnt} < BUF_LIM))
        else $error("decoded byte count reached the buffer size");

    a_no_result_midway: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(w_in_acc && i_last)) |=> !o_valid)
        else $error("verdict appeared without a last byte");
`endif

endmodule
